>>> rtl/svq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svq_pkg: shared types for the split virtqueue driver ring
// Command and status codes plus the request and response word layouts.
// ----------------------------------------------------------------------------
package svq_pkg;

   localparam int ADDR_W    = 64;
   localparam int LEN_W     = 32;
   localparam int ID_W      = 8;
   localparam int COUNT_W   = 16;
   localparam int CFG_W     = 4;
   localparam logic [CFG_W-1:0] CFG_RESET_LOG2 = 4'd8;

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_COMPLETE = 2'd1,
      CMD_FETCH    = 2'd2,
      CMD_KICK     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_NO_USED = 2'd2,
      STATUS_BAD_ID  = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type           command;
      logic [ADDR_W-1:0] buffer_address;
      logic [LEN_W-1:0]  buffer_length;
      logic [ID_W-1:0]   used_id;
      logic [LEN_W-1:0]  used_length;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic [ID_W-1:0]    desc_index;
      logic [LEN_W-1:0]   used_length_out;
      logic [COUNT_W-1:0] avail_index;
      logic               notify;
   } rsp_word_type;

endpackage

>>> rtl/split_virtqueue_driver_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_virtqueue_driver_ring: driver side of a split virtqueue
// Free descriptor list, available ring index and used ring, one command
// per word, add / complete / fetch / kick.
// ----------------------------------------------------------------------------
// A request word is taken into an input register and its response is then
// registered in the output register, and one word is accepted every cycle
// while the response side keeps up. The free list head and its successor sit
// in registers, and the link memory is read ahead at the successor's address
// (with write bypass), which lets back-to-back adds and fetches run at full
// rate; the used ring is read ahead the same way at the next unread slot.
// After reset and after every write of queue_size_log2 the link memory is
// rebuilt by a clearing pass over n entries, n = 2^queue_size_log2 limited
// to QUEUE_DEPTH, one entry per cycle; req_ready stays low during the pass
// while csr writes are still taken. Buffer address and length are accepted
// but have no effect on any response.
module split_virtqueue_driver_ring #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  svq_pkg::req_word_type      req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output svq_pkg::rsp_word_type      rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [svq_pkg::CFG_W-1:0]  csr_data
);
   import svq_pkg::*;

   localparam int IW       = $clog2(QUEUE_DEPTH);
   localparam int LW       = IW + 1;
   localparam int MAX_LOG2 = $clog2(QUEUE_DEPTH + 1) - 1;
   localparam int NW       = IW + 2;
   localparam logic [LW-1:0] LINK_END = {1'b1, {IW{1'b0}}};

   // configuration and clearing pass
   logic [CFG_W-1:0] cfg_ff, cfg_in;
   logic             sweep_ff, sweep_in;
   logic [IW-1:0]    sweep_cnt_ff, sweep_cnt_in;

   // pipeline registers
   logic          stg_valid_ff, stg_valid_in;
   req_word_type  stg_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_data_ff, rsp_result;

   // queue state
   logic [LW-1:0]      head_ff, head_in;
   logic [LW-1:0]      next_ff, next_in;
   logic [COUNT_W-1:0] avail_count_ff, avail_count_in;
   logic [COUNT_W-1:0] used_count_ff, used_count_in;
   logic [COUNT_W-1:0] last_seen_ff, last_seen_in;

   // link memory
   logic [LW-1:0] link_mem [QUEUE_DEPTH];
   logic [LW-1:0] link_q_ff;
   logic          link_byp_sel_ff;
   logic [LW-1:0] link_byp_ff;
   logic          link_we;
   logic [IW-1:0] link_wa, link_ra;
   logic [LW-1:0] link_wd, link_rd, link_rd_init;

   // used ring memory
   logic [ID_W+LEN_W-1:0] used_mem [QUEUE_DEPTH];
   logic [ID_W+LEN_W-1:0] used_q_ff, used_byp_ff, used_wd, used_rd;
   logic                  used_byp_sel_ff;
   logic                  used_we;
   logic [IW-1:0]         used_wa, used_ra;

   logic [3:0]    eff_log2;
   logic [NW-1:0] queue_n;
   logic [IW-1:0] mask;
   logic          go;
   logic          id_ok;
   logic [ID_W-1:0]  fetch_id;
   logic [LEN_W-1:0] fetch_len;

   // queue size, limited to the memory depth
   always_comb begin
      eff_log2 = (cfg_ff > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : cfg_ff;
      queue_n  = NW'(1) << eff_log2;
      mask     = IW'(queue_n - NW'(1));
   end

   // handshakes
   assign go        = stg_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !sweep_ff && (!stg_valid_ff || go);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign link_rd   = link_byp_sel_ff ? link_byp_ff : link_q_ff;
   assign used_rd   = used_byp_sel_ff ? used_byp_ff : used_q_ff;
   assign fetch_id  = used_rd[ID_W+LEN_W-1:LEN_W];
   assign fetch_len = used_rd[LEN_W-1:0];
   assign id_ok     = (NW+ID_W)'(stg_data_ff.used_id) < (NW+ID_W)'(queue_n);

   // link value expected at the successor right after a clearing pass
   assign link_rd_init = (queue_n <= NW'(2)) ? LINK_END : {1'b0, IW'(2)};

   // command execution
   always_comb begin
      head_in        = head_ff;
      next_in        = next_ff;
      avail_count_in = avail_count_ff;
      used_count_in  = used_count_ff;
      last_seen_in   = last_seen_ff;
      link_we        = 1'b0;
      link_wa        = head_ff[IW-1:0];
      link_wd        = '0;
      used_we        = 1'b0;
      used_wa        = used_count_ff[IW-1:0] & mask;
      used_wd        = {stg_data_ff.used_id, stg_data_ff.used_length};
      rsp_result     = '0;
      rsp_result.status = STATUS_OK;

      if (sweep_ff) begin
         // rebuild the free list as 0, 1, ..., n-1, end
         link_we        = 1'b1;
         link_wa        = sweep_cnt_ff;
         link_wd        = (sweep_cnt_ff == mask) ? LINK_END : {1'b0, sweep_cnt_ff + IW'(1)};
         head_in        = '0;
         next_in        = (queue_n == NW'(1)) ? LINK_END : {1'b0, IW'(1)};
         avail_count_in = '0;
         used_count_in  = '0;
         last_seen_in   = '0;
      end else if (go) begin
         case (stg_data_ff.command)
            CMD_ADD: begin
               if (head_ff[IW]) begin
                  rsp_result.status = STATUS_NO_FREE;
               end else begin
                  link_we = 1'b1;
                  link_wa = head_ff[IW-1:0];
                  link_wd = '0;
                  head_in = next_ff;
                  if (next_ff[IW]) begin
                     next_in = LINK_END;
                  end else if (next_ff[IW-1:0] == head_ff[IW-1:0]) begin
                     // successor is the entry just taken, its link was cleared
                     next_in = '0;
                  end else begin
                     next_in = link_rd;
                  end
                  avail_count_in        = avail_count_ff + COUNT_W'(1);
                  rsp_result.desc_index = ID_W'(head_ff[IW-1:0]);
               end
            end
            CMD_COMPLETE: begin
               if (!id_ok) begin
                  rsp_result.status = STATUS_BAD_ID;
               end else begin
                  used_we       = 1'b1;
                  used_count_in = used_count_ff + COUNT_W'(1);
               end
            end
            CMD_FETCH: begin
               if (last_seen_ff == used_count_ff) begin
                  rsp_result.status = STATUS_NO_USED;
               end else begin
                  // push the returned descriptor onto the free list
                  link_we      = 1'b1;
                  link_wa      = IW'(fetch_id);
                  link_wd      = head_ff;
                  head_in      = {1'b0, IW'(fetch_id)};
                  next_in      = head_ff;
                  last_seen_in = last_seen_ff + COUNT_W'(1);
                  rsp_result.desc_index      = fetch_id;
                  rsp_result.used_length_out = fetch_len;
               end
            end
            CMD_KICK: begin
               rsp_result.notify = 1'b1;
            end
            default: begin
               rsp_result.status = STATUS_OK;
            end
         endcase
      end
      rsp_result.avail_index = avail_count_in;
   end

   // read-ahead addresses
   assign link_ra = next_in[IW-1:0];
   assign used_ra = last_seen_in[IW-1:0] & mask;

   // control next state
   always_comb begin
      cfg_in       = cfg_ff;
      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      if (csr_valid && csr_ready) begin
         cfg_in       = csr_data;
         sweep_in     = 1'b1;
         sweep_cnt_in = '0;
      end else if (sweep_ff) begin
         if (sweep_cnt_ff == mask) begin
            sweep_in = 1'b0;
         end else begin
            sweep_cnt_in = sweep_cnt_ff + IW'(1);
         end
      end

      stg_valid_in = stg_valid_ff;
      if (req_valid && req_ready) begin
         stg_valid_in = 1'b1;
      end else if (go) begin
         stg_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= CFG_RESET_LOG2;
         sweep_ff       <= 1'b1;
         sweep_cnt_ff   <= '0;
         stg_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         head_ff        <= '0;
         next_ff        <= '0;
         avail_count_ff <= '0;
         used_count_ff  <= '0;
         last_seen_ff   <= '0;
      end else begin
         cfg_ff         <= cfg_in;
         sweep_ff       <= sweep_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         stg_valid_ff   <= stg_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         head_ff        <= head_in;
         next_ff        <= next_in;
         avail_count_ff <= avail_count_in;
         used_count_ff  <= used_count_in;
         last_seen_ff   <= last_seen_in;
      end
   end

   // word registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_data_ff <= req_data;
      end
      if (go) begin
         rsp_data_ff <= rsp_result;
      end
   end

   // link memory, registered read
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_q_ff <= link_mem[link_ra];
   end

   // link read bypass, also loads the post-clear value
   always_ff @(posedge clock) begin
      link_byp_sel_ff <= sweep_ff || (link_we && (link_wa == link_ra));
      link_byp_ff     <= sweep_ff ? link_rd_init : link_wd;
   end

   // used ring memory, registered read
   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      used_q_ff <= used_mem[used_ra];
   end

   // used ring read bypass
   always_ff @(posedge clock) begin
      used_byp_sel_ff <= used_we && (used_wa == used_ra);
      used_byp_ff     <= used_wd;
   end

   // checks
   a_no_req_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !req_ready)
      else $error("request taken during clearing pass");

   a_csr_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> sweep_ff)
      else $error("csr write did not start clearing pass");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      (!sweep_ff && !head_ff[IW]) |-> (NW'(head_ff[IW-1:0]) < queue_n))
      else $error("free list head outside queue");

   a_no_free_status: assert property (@(posedge clock) disable iff (reset)
      (go && stg_data_ff.command == CMD_ADD && head_ff[IW])
      |=> (rsp_valid_ff && rsp_data_ff.status == STATUS_NO_FREE))
      else $error("add on empty free list not reported");

   a_notify_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.notify) |-> (rsp_data_ff.status == STATUS_OK))
      else $error("notify with failing status");

endmodule
